/* rtl/imh_pkg.sv */
// shared types, constants and codes for the indexed min-heap
package imh_pkg;

    localparam int DEPTH     = 1024;
    localparam int KEY_W     = 32;
    localparam int ID_W      = 10;
    localparam int POS_W     = 10;
    localparam int CNT_W     = 11;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_REM_POS = 2'd1;
    localparam logic [1:0] KIND_REM_ID  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_DUP     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IDREAD,
        S_TGTREAD,
        S_LASTREAD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN,
        S_OUT
    } state_t;

    // one heap slot write, also updates the position map
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } slot_wr_t;

endpackage

/* rtl/imh_slot_mem.sv */
// heap slot store: key and id per slot, one write and two reads per cycle
module imh_slot_mem
    import imh_pkg::*;
(
    input  logic             clk,
    input  slot_wr_t         wr,
    input  logic [POS_W-1:0] rd_a_addr,
    input  logic [POS_W-1:0] rd_b_addr,
    output logic [KEY_W-1:0] rd_a_key,
    output logic [ID_W-1:0]  rd_a_id,
    output logic [KEY_W-1:0] rd_b_key,
    output logic [ID_W-1:0]  rd_b_id
);

    logic [KEY_W+ID_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.key, wr.id};
        end
        {rd_a_key, rd_a_id} <= mem[rd_a_addr];
        {rd_b_key, rd_b_id} <= mem[rd_b_addr];
    end

endmodule

/* rtl/imh_pos_map.sv */
// position map from item id to heap slot, with presence bits
module imh_pos_map
    import imh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slot_wr_t         wr,
    input  logic             pres_set,
    input  logic             pres_clr,
    input  logic [ID_W-1:0]  pres_id,
    input  logic [ID_W-1:0]  rd_id,
    output logic [POS_W-1:0] rd_pos,
    output logic             present,
    output logic             clear_done
);

    logic [POS_W-1:0] mem [DEPTH];
    logic             pres_mem [DEPTH];
    logic [ID_W:0]    clr_reg, clr_next;

    // presence bits are wiped one entry per cycle after reset
    assign clear_done = (clr_reg == (ID_W+1)'(DEPTH));
    assign clr_next   = clear_done ? clr_reg : clr_reg + (ID_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.id] <= wr.addr;
        end
        rd_pos <= mem[rd_id];
    end

    always_ff @(posedge clk)
    begin
        if (!clear_done)
        begin
            pres_mem[clr_reg[ID_W-1:0]] <= 1'b0;
        end
        else if (pres_set)
        begin
            pres_mem[pres_id] <= 1'b1;
        end
        else if (pres_clr)
        begin
            pres_mem[pres_id] <= 1'b0;
        end
        present <= pres_mem[rd_id];
    end

endmodule

/* rtl/indexed_min_heap_core.sv */
// indexed binary min-heap top level: request sequencer over slot and position memories
// sequence: rejected requests end after the id read, a position past the fill after the
//   target read, removal of the last slot after the last-slot read; an insert sifts up,
//   a remove sifts up then down; one transaction at a time, each sift level being a slot
//   read and then a compare-and-write step
// reset: asynchronous active low; heap empty; presence bits cleared by a
//   pass over all entries after reset, input held off until it ends
module indexed_min_heap_core
    import imh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [KEY_W-1:0] key,
    input  logic [ID_W-1:0]  item_id,
    input  logic [POS_W-1:0] position,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [ID_W-1:0]  removed_id,
    output logic [KEY_W-1:0] removed_key,
    output logic [CNT_W-1:0] entry_count
);

    state_t state_reg, state_next;

    logic [1:0]       kind_reg;
    logic [KEY_W-1:0] k_reg, k_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [1:0]       status_reg, status_next;
    logic [ID_W-1:0]  rid_reg, rid_next;
    logic [KEY_W-1:0] rkey_reg, rkey_next;

    slot_wr_t         wr;
    logic [POS_W-1:0] rd_a_addr, rd_b_addr;
    logic [KEY_W-1:0] rd_a_key, rd_b_key;
    logic [ID_W-1:0]  rd_a_id, rd_b_id;
    logic             pres_set, pres_clr;
    logic [ID_W-1:0]  pres_id;
    logic [POS_W-1:0] map_pos;
    logic             present;
    logic             map_ready;
    logic             accept;

    logic [CNT_W:0]   child_a, child_b;
    logic [POS_W-1:0] parent;
    logic             take_b;
    logic [KEY_W-1:0] ck;
    logic [ID_W-1:0]  cid;

    imh_slot_mem u_slots (
        .clk       (clk),
        .wr        (wr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_key  (rd_a_key),
        .rd_a_id   (rd_a_id),
        .rd_b_key  (rd_b_key),
        .rd_b_id   (rd_b_id)
    );

    imh_pos_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .pres_set   (pres_set),
        .pres_clr   (pres_clr),
        .pres_id    (pres_id),
        .rd_id      (accept ? item_id : id_reg),
        .rd_pos     (map_pos),
        .present    (present),
        .clear_done (map_ready)
    );

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE) && map_ready;
    assign out_valid = (state_reg == S_OUT);
    assign status      = status_reg;
    assign removed_id  = rid_reg;
    assign removed_key = rkey_reg;
    assign entry_count = fill_reg;

    assign parent  = (pos_reg - POS_W'(1)) >> 1;
    assign child_a = {pos_reg, 1'b1} + (CNT_W+1)'(0);
    assign child_b = child_a + (CNT_W+1)'(1);
    // right child only if it exists and is strictly smaller
    assign take_b  = (child_b < {1'b0, fill_reg}) && (rd_b_key < rd_a_key);
    assign ck      = take_b ? rd_b_key : rd_a_key;
    assign cid     = take_b ? rd_b_id : rd_a_id;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_IDREAD;
                end
            end
            S_IDREAD:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (fill_reg >= CNT_W'(DEPTH) || present)
                        state_next = S_OUT;
                    else
                        state_next = S_UP_RD;
                end
                else if (kind_reg == KIND_REM_POS || (kind_reg == KIND_REM_ID && present))
                    state_next = S_TGTREAD;
                else
                    state_next = S_OUT;
            end
            S_TGTREAD:
            begin
                if ({1'b0, pos_reg} >= fill_reg)
                    state_next = S_OUT;
                else
                    state_next = S_LASTREAD;
            end
            S_LASTREAD:
            begin
                if ({1'b0, pos_reg} == fill_reg)
                    state_next = S_OUT;
                else
                    state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                    state_next = S_DN_RD;
                else
                    state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (rd_a_key > k_reg)
                    state_next = S_UP_RD;
                else
                    state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (child_a >= {1'b0, fill_reg} || kind_reg == KIND_INSERT)
                    state_next = S_FIN;
                else
                    state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (k_reg > ck)
                    state_next = S_DN_RD;
                else
                    state_next = S_FIN;
            end
            S_FIN:
                state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        k_next      = k_reg;
        id_next     = id_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        rkey_next   = rkey_reg;
        wr          = '0;
        rd_a_addr   = pos_reg;
        rd_b_addr   = POS_W'(fill_reg - CNT_W'(1));
        pres_set    = 1'b0;
        pres_clr    = 1'b0;
        pres_id     = id_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next      = key;
                id_next     = item_id;
                pos_next    = position;
                status_next = ST_OK;
                rid_next    = '0;
                rkey_next   = '0;
            end
            S_IDREAD:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (fill_reg >= CNT_W'(DEPTH))
                        status_next = ST_FULL;
                    else if (present)
                        status_next = ST_DUP;
                    else
                    begin
                        pos_next  = POS_W'(fill_reg);
                        fill_next = fill_reg + CNT_W'(1);
                        pres_set  = 1'b1;
                    end
                end
                else if (kind_reg == KIND_REM_ID && present)
                begin
                    pos_next  = map_pos;
                    rd_a_addr = map_pos;
                end
                else if (kind_reg != KIND_REM_POS)
                    status_next = ST_EMPTY;
            end
            S_TGTREAD:
            begin
                // slot read of target issued; last slot read in parallel
                if ({1'b0, pos_reg} >= fill_reg)
                    status_next = ST_EMPTY;
                else
                    fill_next = fill_reg - CNT_W'(1);
            end
            S_LASTREAD:
            begin
                rid_next  = rd_a_id;
                rkey_next = rd_a_key;
                pres_clr  = 1'b1;
                pres_id   = rd_a_id;
                k_next    = rd_b_key;
                id_next   = rd_b_id;
            end
            S_UP_RD:
            begin
                rd_a_addr = parent;
            end
            S_UP_CMP:
            begin
                if (rd_a_key > k_reg)
                begin
                    wr.en    = 1'b1;
                    wr.addr  = pos_reg;
                    wr.key   = rd_a_key;
                    wr.id    = rd_a_id;
                    pos_next = parent;
                end
            end
            S_DN_RD:
            begin
                rd_a_addr = POS_W'(child_a);
                rd_b_addr = POS_W'(child_b);
            end
            S_DN_CMP:
            begin
                if (k_reg > ck)
                begin
                    wr.en    = 1'b1;
                    wr.addr  = pos_reg;
                    wr.key   = ck;
                    wr.id    = cid;
                    pos_next = take_b ? POS_W'(child_b) : POS_W'(child_a);
                end
            end
            S_FIN:
            begin
                wr.en   = 1'b1;
                wr.addr = pos_reg;
                wr.key  = k_reg;
                wr.id   = id_reg;
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
        end
        k_reg      <= k_next;
        id_reg     <= id_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rkey_reg   <= rkey_next;
    end

endmodule

/* rtl/imh_checker.sv */
// port-level checks for the indexed min-heap, bound to the top level
module imh_checker
    import imh_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       status,
    input logic [ID_W-1:0]  removed_id,
    input logic [KEY_W-1:0] removed_key,
    input logic [CNT_W-1:0] entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_W'(DEPTH))
        else $error("entry count out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> removed_id == '0 && removed_key == '0)
        else $error("failed transaction carries removed data");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("new transaction taken while result pending");

endmodule

bind indexed_min_heap_core imh_checker u_imh_checker (.*);

/* tb/sv/tb.sv */
// indexed min-heap core testbench: directed table, random traffic, then fill to capacity
`timescale 1ns / 1ps

module tb;
    import imh_pkg::*;

    localparam int N_RANDOM  = 60;
    localparam int CYC_LIMIT = 400000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  item_id;
    logic [POS_W-1:0] position;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  removed_id;
    logic [KEY_W-1:0] removed_key;
    logic [CNT_W-1:0] entry_count;

    indexed_min_heap_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .key(key), .item_id(item_id), .position(position),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .removed_id(removed_id),
        .removed_key(removed_key), .entry_count(entry_count)
    );

    typedef struct packed {
        logic [1:0]       st;
        logic [ID_W-1:0]  rid;
        logic [KEY_W-1:0] rkey;
        logic [CNT_W-1:0] cnt;
    } heap_reply_t;

    typedef struct {
        logic [1:0]       k;
        logic [KEY_W-1:0] kv;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
        bit               fixed;
        heap_reply_t      want;
    } request_row_t;

    // predictor state
    logic [KEY_W-1:0] hp_key [DEPTH];
    logic [ID_W-1:0]  hp_id  [DEPTH];
    int               id_slot [DEPTH];
    bit               id_in  [DEPTH];
    int               hp_fill;

    heap_reply_t replies_due[$];
    int          errors;
    int          cycles;
    bit          quiet;

    function automatic void place(int p, logic [KEY_W-1:0] kv, logic [ID_W-1:0] id);
        hp_key[p] = kv;
        hp_id[p] = id;
        id_slot[id] = p;
    endfunction

    function automatic int sift_up(int p);
        logic [KEY_W-1:0] kv;
        logic [ID_W-1:0]  id;
        int               up;
        kv = hp_key[p];
        id = hp_id[p];
        while (p > 0)
        begin
            up = (p - 1) / 2;
            if (hp_key[up] > kv)
            begin
                place(p, hp_key[up], hp_id[up]);
                p = up;
            end
            else
                break;
        end
        place(p, kv, id);
        return p;
    endfunction

    function automatic void sift_down(int p);
        logic [KEY_W-1:0] kv;
        logic [ID_W-1:0]  id;
        int               c;
        kv = hp_key[p];
        id = hp_id[p];
        forever
        begin
            c = 2 * p + 1;
            if (c >= hp_fill)
                break;
            if (c + 1 < hp_fill && hp_key[c + 1] < hp_key[c])
                c = c + 1;
            if (kv > hp_key[c])
            begin
                place(p, hp_key[c], hp_id[c]);
                p = c;
            end
            else
                break;
        end
        place(p, kv, id);
    endfunction

    function automatic heap_reply_t heap_apply(logic [1:0] k, logic [KEY_W-1:0] kv,
                                               logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
        heap_reply_t r;
        int          p;
        bit          ok;
        r = '0;
        if (k == KIND_INSERT)
        begin
            if (hp_fill >= DEPTH)
                r.st = ST_FULL;
            else if (id_in[id])
                r.st = ST_DUP;
            else
            begin
                hp_fill++;
                id_in[id] = 1;
                place(hp_fill - 1, kv, id);
                void'(sift_up(hp_fill - 1));
                r.st = ST_OK;
            end
        end
        else if (k == KIND_REM_POS || k == KIND_REM_ID)
        begin
            ok = 1;
            p = int'(pos);
            if (k == KIND_REM_ID)
            begin
                ok = id_in[id];
                p = ok ? id_slot[id] : 0;
            end
            if (ok && p < hp_fill)
            begin
                r.st = ST_OK;
                r.rid = hp_id[p];
                r.rkey = hp_key[p];
                hp_fill--;
                id_in[r.rid] = 0;
                if (p < hp_fill)
                begin
                    place(p, hp_key[hp_fill], hp_id[hp_fill]);
                    sift_down(sift_up(p));
                end
            end
            else
                r.st = ST_EMPTY;
        end
        else
            r.st = ST_EMPTY;
        r.cnt = CNT_W'(hp_fill);
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("[indexed_min_heap_core] ERROR");
            $finish;
        end
    end

    // result side: random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        heap_reply_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t unexpected transaction st=%0d", $time, status);
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.st || removed_id !== want.rid ||
                        removed_key !== want.rkey || entry_count !== want.cnt)
                    begin
                        $display("%0t mismatch exp st=%0d id=%0d key=%h cnt=%0d",
                                 $time, want.st, want.rid, want.rkey, want.cnt);
                        $display("%0t          got st=%0d id=%0d key=%h cnt=%0d",
                                 $time, status, removed_id, removed_key, entry_count);
                        errors++;
                    end
                end
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
        end
        else
            out_ready <= 1'b0;
    end

    task automatic send(logic [1:0] k, logic [KEY_W-1:0] kv, logic [ID_W-1:0] id,
                        logic [POS_W-1:0] pos, bit fixed, heap_reply_t want);
        heap_reply_t pr;
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        key <= kv;
        item_id <= id;
        position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        pr = heap_apply(k, kv, id, pos);
        if (fixed && pr != want)
        begin
            $display("%0t directed row disagrees with predictor exp=%h pred=%h",
                     $time, want, pr);
            errors++;
        end
        replies_due.push_back(pr);
    endtask

    function automatic heap_reply_t rep(logic [1:0] st, int rid, logic [KEY_W-1:0] rk, int c);
        heap_reply_t r;
        r.st = st;
        r.rid = ID_W'(rid);
        r.rkey = rk;
        r.cnt = CNT_W'(c);
        return r;
    endfunction

    initial
    begin
        request_row_t rows[$];
        request_row_t rw;
        int           mode;
        int           r;
        int           pool;
        errors = 0;
        quiet = 0;
        hp_fill = 0;
        foreach (id_in[i]) id_in[i] = 0;
        rst_n = 0;
        in_valid = 0;
        kind = KIND_INSERT;
        key = '0;
        item_id = '0;
        position = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: fixed expectations where obvious, else predictor only
        rows.push_back('{KIND_REM_POS, 0, 0, 0, 1, rep(ST_EMPTY, 0, 0, 0)});
        rows.push_back('{KIND_REM_ID, 0, 1023, 0, 1, rep(ST_EMPTY, 0, 0, 0)});
        rows.push_back('{KIND_UNUSED, 32'hffffffff, 1023, 1023, 1, rep(ST_EMPTY, 0, 0, 0)});
        rows.push_back('{KIND_INSERT, 32'hffffffff, 1023, 1023, 1, rep(ST_OK, 0, 0, 1)});
        rows.push_back('{KIND_INSERT, 32'h5, 1023, 0, 1, rep(ST_DUP, 0, 0, 1)});
        rows.push_back('{KIND_INSERT, 32'h0, 0, 0, 1, rep(ST_OK, 0, 0, 2)});
        rows.push_back('{KIND_INSERT, 32'h3f800000, 5, 0, 0, '0});
        rows.push_back('{KIND_INSERT, 32'h3f800000, 6, 0, 0, '0});
        rows.push_back('{KIND_INSERT, 32'h80000000, 7, 0, 0, '0});
        rows.push_back('{KIND_INSERT, 32'h3f800000, 8, 0, 0, '0});
        rows.push_back('{KIND_REM_POS, 0, 0, 1023, 1, rep(ST_EMPTY, 0, 0, 6)});
        rows.push_back('{KIND_REM_POS, 0, 0, 6, 1, rep(ST_EMPTY, 0, 0, 6)});
        rows.push_back('{KIND_REM_POS, 0, 0, 5, 0, '0});
        rows.push_back('{KIND_REM_POS, 0, 0, 0, 1, rep(ST_OK, 0, 0, 4)});
        rows.push_back('{KIND_REM_ID, 0, 1023, 0, 0, '0});
        rows.push_back('{KIND_REM_ID, 0, 1023, 0, 1, rep(ST_EMPTY, 0, 0, 3)});
        rows.push_back('{KIND_REM_POS, 0, 0, 1, 0, '0});
        rows.push_back('{KIND_REM_POS, 0, 0, 0, 0, '0});
        rows.push_back('{KIND_REM_POS, 0, 0, 0, 0, '0});
        rows.push_back('{KIND_REM_POS, 0, 0, 0, 1, rep(ST_EMPTY, 0, 0, 0)});
        foreach (rows[i])
            send(rows[i].k, rows[i].kv, rows[i].id, rows[i].pos, rows[i].fixed, rows[i].want);

        // random part: phases of filling and draining, small id pool most of the time
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                in_valid <= 0;
                while (replies_due.size() != 0)
                    @(posedge clk);
            end
            mode = (n / 20) % 3;
            pool = (n % 40 < 8) ? 1023 : 63;
            r = $urandom_range(99);
            rw.kv = $urandom();
            if ($urandom_range(3) == 0)
                rw.kv = $urandom_range(15);
            rw.id = ID_W'($urandom_range(pool));
            if (r < (mode == 0 ? 70 : (mode == 1 ? 45 : 25)))
                rw.k = KIND_INSERT;
            else if (r < 85)
                rw.k = KIND_REM_ID;
            else if (r < 98)
                rw.k = KIND_REM_POS;
            else
                rw.k = KIND_UNUSED;
            if (rw.k == KIND_REM_POS)
                rw.pos = ($urandom_range(9) == 0 || hp_fill == 0) ? POS_W'($urandom())
                        : POS_W'($urandom_range(hp_fill - 1));
            else
                rw.pos = POS_W'($urandom());
            send(rw.k, rw.kv, rw.id, rw.pos, 0, '0);
        end

        // fill to capacity so the full case and a large heap are exercised
        for (int i = 0; i < DEPTH; i++)
        begin
            quiet = (i >= 300 && i < 600);
            if (!id_in[i])
                send(KIND_INSERT, $urandom(), ID_W'(i), POS_W'($urandom()), 0, '0);
        end
        quiet = 0;
        send(KIND_INSERT, 32'h1, 0, 0, 1, rep(ST_FULL, 0, 0, DEPTH));
        for (int i = 0; i < 8; i++)
            send(KIND_REM_POS, 0, 0, POS_W'($urandom_range(DEPTH - 1)), 0, '0);

        in_valid <= 0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("[indexed_min_heap_core] OK");
        else
            $display("[indexed_min_heap_core] ERROR");
        $finish;
    end

endmodule
